// ----- hdl/psm_pkg.sv -----
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, sizes and the region table for the partitioned stack unit.
// ----------------------------------------------------------------------------
package psm_pkg;

  // Storage sizes
  localparam int MEM_DEPTH   = 16;
  localparam int STACK_LIMIT = 4;
  localparam int RESULT_CAP  = 16;

  // Derived widths
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CW     = $clog2(MEM_DEPTH + 1);   // counts, bases, sizes
  localparam int CNT_W  = 3;                       // stack_count register
  localparam int SIDX_W = 2;                       // stack_index field
  localparam int DATA_W = 32;

  // Stream payload widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Reset stack count: four, or fewer if the limit is lower
  localparam int RST_COUNT = (STACK_LIMIT < 4) ? STACK_LIMIT : 4;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_DUMP = 2'd2
  } psm_mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OVF     = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_INVALID = 2'd3
  } psm_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DUMP
  } psm_state_t;

  // Region length per stack count, indexed by count (entry 0 unused)
  typedef logic [STACK_LIMIT:0][CW-1:0] psm_quot_tab_t;

  localparam int QUOT_1 = MEM_DEPTH / 1;
  localparam int QUOT_2 = MEM_DEPTH / 2;
  localparam int QUOT_3 = MEM_DEPTH / 3;
  localparam int QUOT_4 = MEM_DEPTH / 4;

  localparam psm_quot_tab_t QUOT_TAB = {CW'(QUOT_4), CW'(QUOT_3), CW'(QUOT_2),
                                        CW'(QUOT_1), CW'(0)};

endpackage

// ----- hdl/partitioned_multi_stack_unit.sv -----
// ----------------------------------------------------------------------------
// partitioned_multi_stack_unit
// Several stacks sharing one word memory, each in its own region; the last region takes the remainder.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per beat: push, pop or dump of one stack.
//   out_* : results; tlast marks the final result of a request.
//   cfg_* : write the stack count (clamped to 1..STACK_LIMIT) while idle;
//           every write empties all stacks.
// Request handling:
//   Push and refused requests: result valid in the cycle after accept,
//   and a new request is taken every cycle while results are taken.
//   Pop: the memory read is registered in rdata_r, then loaded into the
//   output register; no new request is taken until it is loaded.
//   Dump: the first element is read at accept, then one element per cycle
//   from the memory read port while the output is not stalled; input is held
//   off until the last element is loaded. Empty dump gives one result like a push.
// Reset: all stacks empty, stack count four; memory contents are not cleared.
// Stall: a result waits in the output register; the unit keeps it and stops
//   taking requests or issuing dump reads until it is taken.
// ----------------------------------------------------------------------------
module partitioned_multi_stack_unit
  import psm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // mode[1:0], stack_index[3:2], value[35:4]
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status[1:0], value_res[33:2]
  output logic                   out_tlast,
  // Configuration
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wdata
);

  // Request fields
  logic [1:0]        in_mode;
  logic [SIDX_W-1:0] in_sidx;
  logic [DATA_W-1:0] in_value;

  assign in_mode  = in_tdata[1:0];
  assign in_sidx  = in_tdata[3:2];
  assign in_value = in_tdata[35:4];

  // State
  psm_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CW-1:0]     fill_r [STACK_LIMIT];
  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Dump walk
  logic [ADDR_W-1:0] dump_base_r, dump_base_nxt;
  logic [CW-1:0]     dump_idx_r, dump_idx_nxt;
  logic [CW-1:0]     dump_end_r, dump_end_nxt;

  // Output register
  logic              out_valid_r;
  psm_status_t       out_status_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r;

  // Decode results
  logic              slot_free, acc;
  logic              op_invalid;
  logic [CW-1:0]     quot_sel, fill_sel, base, rsize;
  logic [CW:0]       region_end;
  logic              is_full, is_empty;
  logic              go_pop, go_dump;

  // Datapath controls
  logic              out_load;
  psm_status_t       out_status_nxt;
  logic [DATA_W-1:0] out_value_nxt;
  logic              out_last_nxt;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              fill_we;
  logic [CW-1:0]     fill_wval;
  logic              dump_is_last;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_tvalid && in_tready;

  // Decode the addressed stack: region base, size and fill
  always_comb begin
    quot_sel = '0;
    fill_sel = '0;
    for (int k = 1; k <= STACK_LIMIT; k++) begin
      if (int'(count_r) == k) quot_sel = QUOT_TAB[k];
    end
    for (int k = 0; k < STACK_LIMIT; k++) begin
      if (int'(in_sidx) == k) fill_sel = fill_r[k];
    end
    op_invalid = ({1'b0, in_sidx} >= count_r) || (int'(in_sidx) >= STACK_LIMIT) ||
                 !((in_mode == MODE_PUSH) || (in_mode == MODE_POP) ||
                   (in_mode == MODE_DUMP));
    base = CW'(quot_sel * in_sidx);
    if (({1'b0, in_sidx} + 3'd1) >= count_r) begin
      region_end = (CW+1)'(MEM_DEPTH);
    end else begin
      region_end = {1'b0, base} + {1'b0, quot_sel};
    end
    rsize    = CW'(region_end - {1'b0, base});
    is_full  = (fill_sel >= rsize);
    is_empty = (fill_sel == '0);
    go_pop   = acc && !op_invalid && (in_mode == MODE_POP) && !is_empty;
    go_dump  = acc && !op_invalid && (in_mode == MODE_DUMP) && !is_empty;
  end

  assign dump_is_last = (dump_idx_r == dump_end_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_pop) begin
          state_nxt = ST_POP;
        end else if (go_dump) begin
          state_nxt = ST_DUMP;
        end
      end
      ST_POP: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        if (slot_free && dump_is_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs per state: result load, memory access, fill update
  always_comb begin
    out_load       = 1'b0;
    out_status_nxt = STAT_OK;
    out_value_nxt  = '0;
    out_last_nxt   = 1'b1;
    mem_we         = 1'b0;
    wr_addr        = ADDR_W'({1'b0, base} + {1'b0, fill_sel});
    rd_en          = 1'b0;
    rd_addr        = ADDR_W'({1'b0, base} + {1'b0, fill_sel} - (CW+1)'(1));
    fill_we        = 1'b0;
    fill_wval      = fill_sel;
    dump_base_nxt  = dump_base_r;
    dump_idx_nxt   = dump_idx_r;
    dump_end_nxt   = dump_end_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (op_invalid) begin
            out_load       = 1'b1;
            out_status_nxt = STAT_INVALID;
          end else begin
            unique case (in_mode)
              MODE_PUSH: begin
                out_load = 1'b1;
                if (is_full) begin
                  out_status_nxt = STAT_OVF;
                end else begin
                  mem_we    = 1'b1;
                  fill_we   = 1'b1;
                  fill_wval = fill_sel + CW'(1);
                end
              end
              MODE_POP: begin
                if (is_empty) begin
                  out_load       = 1'b1;
                  out_status_nxt = STAT_EMPTY;
                  out_value_nxt  = '1;
                end else begin
                  rd_en     = 1'b1;
                  fill_we   = 1'b1;
                  fill_wval = fill_sel - CW'(1);
                end
              end
              MODE_DUMP: begin
                if (is_empty) begin
                  out_load       = 1'b1;
                  out_status_nxt = STAT_EMPTY;
                end else begin
                  rd_en         = 1'b1;
                  rd_addr       = ADDR_W'(base);
                  dump_base_nxt = ADDR_W'(base);
                  dump_idx_nxt  = '0;
                  if (fill_sel > CW'(RESULT_CAP)) begin
                    dump_end_nxt = CW'(RESULT_CAP - 1);
                  end else begin
                    dump_end_nxt = fill_sel - CW'(1);
                  end
                end
              end
              default: begin
                out_load       = 1'b1;
                out_status_nxt = STAT_INVALID;
              end
            endcase
          end
        end
      end
      ST_POP: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_value_nxt = rdata_r;
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_value_nxt = rdata_r;
          out_last_nxt  = dump_is_last;
          if (!dump_is_last) begin
            rd_en        = 1'b1;
            rd_addr      = ADDR_W'((CW+1)'(dump_base_r) + {1'b0, dump_idx_r} +
                                   (CW+1)'(1));
            dump_idx_nxt = dump_idx_r + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Stack memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_value;
    if (rd_en)  rdata_r <= mem[rd_addr];
  end

  // Control state, stack count and fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CNT_W'(RST_COUNT);
      out_valid_r <= 1'b0;
      for (int k = 0; k < STACK_LIMIT; k++) fill_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        // Clamp into 1..STACK_LIMIT and empty every stack
        if (cfg_wdata == '0) begin
          count_r <= CNT_W'(1);
        end else if (int'(cfg_wdata) > STACK_LIMIT) begin
          count_r <= CNT_W'(STACK_LIMIT);
        end else begin
          count_r <= cfg_wdata;
        end
        for (int k = 0; k < STACK_LIMIT; k++) fill_r[k] <= '0;
      end else if (fill_we) begin
        for (int k = 0; k < STACK_LIMIT; k++) begin
          if (int'(in_sidx) == k) fill_r[k] <= fill_wval;
        end
      end
    end
  end

  // Result payload and dump walk registers
  always_ff @(posedge clk) begin
    dump_base_r <= dump_base_nxt;
    dump_idx_r  <= dump_idx_nxt;
    dump_end_r  <= dump_end_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-DATA_W-2)'(0), out_value_r, out_status_r};
  assign out_tlast  = out_last_r;

  // Checks
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> slot_free)
    else $error("result loaded over a waiting result");

  a_fill_within_region: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !op_invalid) |-> (fill_sel <= rsize))
    else $error("stack fill exceeds its region");

  a_pop_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> out_load)
    else $error("pop read data not delivered");

  a_dump_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DUMP) && out_load && out_last_nxt) |=> (state_r == ST_IDLE))
    else $error("dump did not finish after its last element");

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (acc && (state_r == ST_IDLE)))
    else $error("memory written outside an accepted push");

endmodule
